// File: rtl/scp_pkg.sv
// Shared constants, types and prefix table of the serial command prefix classifier.
package scp_pkg;

    localparam int FRAME_DEPTH    = 64;
    localparam int POS_W          = $clog2(FRAME_DEPTH + 1);
    localparam int STORE_DEPTH    = 16;
    localparam int IDX_W          = $clog2(STORE_DEPTH);
    localparam int MAX_PREFIX_LEN = 15;
    localparam int NUM_PREFIXES   = 27;
    localparam int CODE_W         = 5;
    localparam int KEY_W          = $clog2(NUM_PREFIXES);

    localparam logic [CODE_W-1:0] CODE_START_TX    = 5'd0;
    localparam logic [CODE_W-1:0] CODE_INPUT_ERROR = 5'd28;
    localparam logic [IDX_W-1:0]  SCAN_LAST        = IDX_W'(MAX_PREFIX_LEN - 1);

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam int         START_TAIL_POS = 11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } scp_state_t;

    typedef struct packed {
        logic init;
        logic step;
    } scp_ctl_t;

    function automatic logic [7:0] prefix_char(input logic [KEY_W-1:0] k,
                                               input logic [IDX_W-1:0] i);
        logic [8*MAX_PREFIX_LEN-1:0] txt;
        int unsigned                 len;
        int unsigned                 p;
        len = 0;
        p   = 0;
        case (k)
            5'd0:    txt = "#SET+FREQ=";
            5'd1:    txt = "#SET+NUM=";
            5'd2:    txt = "#SET+NU_FR=";
            5'd3:    txt = "#SET+GROUP=";
            5'd4:    txt = "#SET+DISP=";
            5'd5:    txt = "#SET+DELAY1=";
            5'd6:    txt = "#SET+DELAY2=";
            5'd7:    txt = "#SET+MESSAGE=";
            5'd8:    txt = "#SET+MODPOW=";
            5'd9:    txt = "#LOAD+NUM";
            5'd10:   txt = "#LOAD+GROUP";
            5'd11:   txt = "#HERD:";
            5'd12:   txt = "#GROUP:";
            5'd13:   txt = "#WIFI+SET+ON=";
            5'd14:   txt = "#WIFI+SET+SSID=";
            5'd15:   txt = "#WIFI+SET+PSK=";
            5'd16:   txt = "#WIFI+SAVESSID=";
            5'd17:   txt = "#WIFI+SAVEPSK=";
            5'd18:   txt = "#WIFI+STA=ON";
            5'd19:   txt = "#WIFI+STA=OFF";
            5'd20:   txt = "#WIFI+SHOWIP=";
            5'd21:   txt = "#WIFI+SHOWRSSI=";
            5'd22:   txt = "#WIFI+GETIP";
            5'd23:   txt = "#WIFI+GETRSSI";
            5'd24:   txt = "#WIFI+OK";
            5'd25:   txt = "#WIFI+FAIL";
            5'd26:   txt = "#FACTORYRESET";
            default: txt = '0;
        endcase
        for (int j = 0; j < MAX_PREFIX_LEN; j++) begin
            if (txt[j*8 +: 8] != 8'h00) begin
                len = 32'(j + 1);
            end
        end
        if (32'(i) >= len) begin
            return 8'h00;
        end
        p = (len - 32'(i) - 1) * 8;
        return txt[p +: 8];
    endfunction

endpackage

// File: rtl/serial_command_prefix_classifier_top.sv
// Top level of the serial command prefix classifier: frame store, sequencer, result register.
// Bytes and line-idle requests are accepted only while the sequencer is idle. After a
// line-idle request, frame positions 0 to 14 are walked through the shared compare stage
// (one position per cycle against all 27 prefixes at once), then the result register is
// loaded, which may wait while the previous result is still stalled; the next request is
// taken only after that load. Only the first 16 frame positions are kept, as no class reads
// further; the write position still wraps at the full frame depth.
module serial_command_prefix_classifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scp_pkg::CODE_W-1:0]    class_code
);

    scp_pkg::scp_state_t               state_reg;
    scp_pkg::scp_state_t               state_next;
    logic [scp_pkg::POS_W-1:0]         pos_reg;
    logic [scp_pkg::POS_W-1:0]         pos_next;
    logic [7:0]                        byte_reg [scp_pkg::STORE_DEPTH];
    logic [scp_pkg::STORE_DEPTH-1:0]   byte_vld_reg;
    logic [scp_pkg::STORE_DEPTH-1:0]   byte_vld_next;
    logic [scp_pkg::IDX_W-1:0]         idx_reg;
    logic [scp_pkg::IDX_W-1:0]         idx_next;
    logic                              start_reg;
    logic                              start_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [scp_pkg::CODE_W-1:0]        class_code_reg;

    logic                              accept_in;
    logic                              rx_byte;
    logic                              idle_req;
    logic [scp_pkg::POS_W-1:0]         wr_pos;
    logic                              wr_in_store;
    logic [scp_pkg::IDX_W-1:0]         wr_idx;
    logic [7:0]                        b0;
    logic [7:0]                        b1;
    logic [7:0]                        b11;
    logic [7:0]                        byte_rd;
    logic                              start_hit_now;
    logic                              scan_done;
    logic                              slot_free;
    logic                              load_out;
    logic                              clear_frame;
    scp_pkg::scp_ctl_t                 ctl;
    logic [scp_pkg::CODE_W-1:0]        code;

    assign accept_in   = in_valid && !in_stall;
    assign rx_byte     = accept_in && !command;
    assign idle_req    = accept_in && command;
    assign wr_pos      = (pos_reg == scp_pkg::POS_W'(scp_pkg::FRAME_DEPTH)) ? '0 : pos_reg;
    assign wr_in_store = wr_pos < scp_pkg::POS_W'(scp_pkg::STORE_DEPTH);
    assign wr_idx      = wr_pos[scp_pkg::IDX_W-1:0];
    assign scan_done   = (state_reg == scp_pkg::S_SCAN) && (idx_reg == scp_pkg::SCAN_LAST);
    assign slot_free   = !out_valid_reg || !out_stall;

    assign b0      = byte_vld_reg[0] ? byte_reg[0] : 8'h00;
    assign b1      = byte_vld_reg[1] ? byte_reg[1] : 8'h00;
    assign b11     = byte_vld_reg[scp_pkg::START_TAIL_POS]
                     ? byte_reg[scp_pkg::START_TAIL_POS] : 8'h00;
    assign byte_rd = byte_vld_reg[idx_reg] ? byte_reg[idx_reg] : 8'h00;

    assign start_hit_now = (b0 == scp_pkg::CHAR_HASH)
                        && ((b1 == scp_pkg::CHAR_P) || (b1 == scp_pkg::CHAR_N))
                        && ((b11 == scp_pkg::CHAR_T) || (b11 == scp_pkg::CHAR_N));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scp_pkg::S_IDLE:
            begin
                if (idle_req) begin
                    state_next = scp_pkg::S_SCAN;
                end
            end
            scp_pkg::S_SCAN:
            begin
                if (scan_done) begin
                    state_next = scp_pkg::S_EMIT;
                end
            end
            scp_pkg::S_EMIT:
            begin
                if (slot_free) begin
                    state_next = scp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scp_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall    = 1'b1;
        ctl.init    = 1'b0;
        ctl.step    = 1'b0;
        load_out    = 1'b0;
        clear_frame = 1'b0;
        case (state_reg)
            scp_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                ctl.init = idle_req;
            end
            scp_pkg::S_SCAN:
            begin
                ctl.step    = 1'b1;
                clear_frame = scan_done;
            end
            scp_pkg::S_EMIT:
            begin
                load_out = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        byte_vld_next = byte_vld_reg;
        if (clear_frame) begin
            pos_next      = '0;
            byte_vld_next = '0;
        end else if (rx_byte) begin
            pos_next = wr_pos + scp_pkg::POS_W'(1);
            if (wr_in_store) begin
                byte_vld_next[wr_idx] = 1'b1;
            end
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        start_next = start_reg;
        if (idle_req) begin
            idx_next   = '0;
            start_next = start_hit_now;
        end else if (ctl.step && !scan_done) begin
            idx_next = idx_reg + scp_pkg::IDX_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= scp_pkg::S_IDLE;
            pos_reg       <= '0;
            byte_vld_reg  <= '0;
            idx_reg       <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            byte_vld_reg  <= byte_vld_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_byte && wr_in_store) begin
            byte_reg[wr_idx] <= data_byte;
        end
        if (load_out) begin
            class_code_reg <= code;
        end
    end

    scp_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .idx       (idx_reg),
        .byte_rd   (byte_rd),
        .start_hit (start_reg),
        .code      (code)
    );

    assign out_valid  = out_valid_reg;
    assign class_code = class_code_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= scp_pkg::POS_W'(scp_pkg::FRAME_DEPTH))
        else $error("write position beyond frame depth");

    a_clear_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |=> (pos_reg == '0) && (byte_vld_reg == '0))
        else $error("frame not cleared after classification");

    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        idle_req |=> ##14 scan_done)
        else $error("scan did not finish after fifteen positions");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (class_code_reg <= scp_pkg::CODE_INPUT_ERROR))
        else $error("result not loaded or out of range");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != scp_pkg::S_IDLE) |-> in_stall)
        else $error("request taken while classifying");

endmodule

// File: rtl/scp_match.sv
// Prefix match lanes, stepped one frame position per cycle, with priority encoder.
module scp_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scp_pkg::scp_ctl_t             ctl,
    input  logic [scp_pkg::IDX_W-1:0]     idx,
    input  logic [7:0]                    byte_rd,
    input  logic                          start_hit,
    output logic [scp_pkg::CODE_W-1:0]    code
);

    logic [scp_pkg::NUM_PREFIXES-1:0] match_reg;
    logic [scp_pkg::NUM_PREFIXES-1:0] match_next;
    logic [scp_pkg::NUM_PREFIXES-1:0] lane_ok;

    always_comb
    begin
        for (int k = 0; k < scp_pkg::NUM_PREFIXES; k++) begin
            logic [7:0] c;
            c = scp_pkg::prefix_char(scp_pkg::KEY_W'(k), idx);
            lane_ok[k] = (c == 8'h00) || (c == byte_rd);
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctl.init) begin
            match_next = '1;
        end else if (ctl.step) begin
            match_next = match_reg & lane_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg <= '0;
        end else begin
            match_reg <= match_next;
        end
    end

    always_comb
    begin
        code = scp_pkg::CODE_INPUT_ERROR;
        for (int k = scp_pkg::NUM_PREFIXES - 1; k >= 0; k--) begin
            if (match_reg[k]) begin
                code = scp_pkg::CODE_W'(k + 1);
            end
        end
        if (start_hit) begin
            code = scp_pkg::CODE_START_TX;
        end
    end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the serial command prefix classifier: stimulus, predictor, checks.
module testbench;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_IDLE    = 1'b1;
    localparam int   NUM_CODES   = 29;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   ITEM_TARGET = 650;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       command = CMD_BYTE;
    logic [7:0]                 data_byte = 8'h00;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [scp_pkg::CODE_W-1:0] class_code;

    string command_prefix [scp_pkg::NUM_PREFIXES] = '{
        "#SET+FREQ=", "#SET+NUM=", "#SET+NU_FR=", "#SET+GROUP=", "#SET+DISP=",
        "#SET+DELAY1=", "#SET+DELAY2=", "#SET+MESSAGE=", "#SET+MODPOW=",
        "#LOAD+NUM", "#LOAD+GROUP", "#HERD:", "#GROUP:", "#WIFI+SET+ON=",
        "#WIFI+SET+SSID=", "#WIFI+SET+PSK=", "#WIFI+SAVESSID=", "#WIFI+SAVEPSK=",
        "#WIFI+STA=ON", "#WIFI+STA=OFF", "#WIFI+SHOWIP=", "#WIFI+SHOWRSSI=",
        "#WIFI+GETIP", "#WIFI+GETRSSI", "#WIFI+OK", "#WIFI+FAIL", "#FACTORYRESET"
    };

    logic [7:0]                 frame_bytes [scp_pkg::FRAME_DEPTH];
    int unsigned                fill_pos;
    logic [scp_pkg::CODE_W-1:0] expected_codes [$];
    logic [scp_pkg::CODE_W-1:0] wanted_code;
    bit                         code_seen [NUM_CODES];
    int                         errors = 0;
    int                         requests_sent = 0;
    int                         codes_checked = 0;
    int                         codes_covered;
    int                         cycle_count = 0;
    int                         hold_left = 0;
    int                         prefix_turn = 0;
    bit                         no_gaps = 1'b0;

    serial_command_prefix_classifier_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .class_code (class_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !no_gaps && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            codes_checked++;
            if (expected_codes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected class_code, expected none, actual %0d",
                         $time, class_code);
            end
            else
            begin
                wanted_code = expected_codes.pop_front();
                if (class_code !== wanted_code)
                begin
                    errors++;
                    $display("%0t: class_code mismatch, expected %0d, actual %0d",
                             $time, wanted_code, class_code);
                end
                if (wanted_code < NUM_CODES)
                    code_seen[wanted_code] = 1'b1;
            end
        end
    end

    function automatic logic [scp_pkg::CODE_W-1:0] classify_frame();
        bit hit;
        if (frame_bytes[0] == scp_pkg::CHAR_HASH &&
            (frame_bytes[1] == scp_pkg::CHAR_P || frame_bytes[1] == scp_pkg::CHAR_N) &&
            (frame_bytes[scp_pkg::START_TAIL_POS] == scp_pkg::CHAR_T ||
             frame_bytes[scp_pkg::START_TAIL_POS] == scp_pkg::CHAR_N))
            return scp_pkg::CODE_START_TX;
        for (int k = 0; k < scp_pkg::NUM_PREFIXES; k++)
        begin
            hit = 1'b1;
            for (int i = 0; i < command_prefix[k].len(); i++)
            begin
                if (i >= scp_pkg::FRAME_DEPTH || frame_bytes[i] != command_prefix[k][i])
                    hit = 1'b0;
            end
            if (hit)
                return scp_pkg::CODE_W'(k + 1);
        end
        return scp_pkg::CODE_INPUT_ERROR;
    endfunction

    function automatic void clear_frame();
        foreach (frame_bytes[i])
            frame_bytes[i] = 8'h00;
        fill_pos = 0;
    endfunction

    function automatic void predict_request(input logic cmd, input logic [7:0] b);
        if (cmd == CMD_BYTE)
        begin
            if (fill_pos >= scp_pkg::FRAME_DEPTH)
                fill_pos = 0;
            frame_bytes[fill_pos] = b;
            fill_pos++;
        end
        else
        begin
            expected_codes.push_back(classify_frame());
            clear_frame();
        end
    endfunction

    function automatic void append_text(ref logic [7:0] q [$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic void append_random(ref logic [7:0] q [$], input int n);
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_request(input logic cmd, input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(cmd, b);
        requests_sent++;
    endtask

    task automatic send_frame(input logic [7:0] q [$]);
        foreach (q[i])
            send_request(CMD_BYTE, q[i]);
        send_request(CMD_IDLE, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_frame();
        logic [7:0] q [$];
        send_frame(q);
        send_frame(q);
    endtask

    task automatic test_start_transmit();
        logic [7:0] q [$];
        q = '{scp_pkg::CHAR_HASH, scp_pkg::CHAR_P, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h41,
              8'h7F, 8'h80, 8'h01, 8'hFE, scp_pkg::CHAR_T};
        send_frame(q);
        q.delete();
        append_text(q, "#WIFI+STA=OF");
        send_frame(q);
    endtask

    task automatic test_store_wrap();
        logic [7:0] q [$];
        append_text(q, "#HERD:");
        append_random(q, scp_pkg::FRAME_DEPTH - 6);
        send_frame(q);
        q.push_back(8'h58);
        send_frame(q);
        q.delete();
        append_random(q, scp_pkg::FRAME_DEPTH);
        q[0] = 8'h41;
        append_text(q, "#GROUP:");
        send_frame(q);
    endtask

    task automatic send_random_frame();
        logic [7:0] q [$];
        int         kind;
        int         k;
        int         pos;
        kind = $urandom_range(0, 99);
        k    = prefix_turn % scp_pkg::NUM_PREFIXES;
        if (kind < 55)
        begin
            prefix_turn++;
            append_text(q, command_prefix[k]);
            append_random(q, $urandom_range(0, 4));
        end
        else if (kind < 70)
        begin
            q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                  : scp_pkg::CHAR_HASH);
            q.push_back($urandom_range(0, 1) ? scp_pkg::CHAR_P : scp_pkg::CHAR_N);
            if ($urandom_range(0, 4) == 0)
                q[1] = 8'($urandom_range(0, 255));
            append_random(q, 9);
            q.push_back($urandom_range(0, 1) ? scp_pkg::CHAR_T : scp_pkg::CHAR_N);
            if ($urandom_range(0, 4) == 0)
                q[scp_pkg::START_TAIL_POS] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0)
                q = q[0:$urandom_range(1, 10)];
            append_random(q, $urandom_range(0, 2));
        end
        else if (kind < 85)
        begin
            k = $urandom_range(0, scp_pkg::NUM_PREFIXES - 1);
            append_text(q, command_prefix[k]);
            pos = $urandom_range(1, q.size() - 1);
            if ($urandom_range(0, 1))
                q = q[0:pos-1];
            else
                q[pos] = 8'($urandom_range(0, 255));
        end
        else if (kind < 97)
        begin
            append_random(q, $urandom_range(0, 14));
            if (q.size() > 0 && $urandom_range(0, 1))
                q[0] = scp_pkg::CHAR_HASH;
        end
        else
        begin
            append_random(q, $urandom_range(scp_pkg::FRAME_DEPTH - 4,
                                            scp_pkg::FRAME_DEPTH + 6));
            if ($urandom_range(0, 1))
                append_text(q,
                            command_prefix[$urandom_range(0, scp_pkg::NUM_PREFIXES - 1)]);
        end
        send_frame(q);
    endtask

    task automatic test_random_frames(input int upto);
        while (requests_sent < upto)
            send_random_frame();
    endtask

    task automatic test_backpressure();
        logic [7:0] q [$];
        no_gaps   = 1'b1;
        hold_left = 300;
        append_text(q, "#HERD:");
        repeat (4)
            send_frame(q);
        no_gaps = 1'b0;
        wait_drained();
    endtask

    task automatic test_steady_stream(input int upto);
        no_gaps = 1'b1;
        test_random_frames(upto);
        no_gaps = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        clear_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_frame();
        test_start_transmit();
        test_store_wrap();
        test_backpressure();
        test_random_frames(requests_sent + (ITEM_TARGET - requests_sent) / 2);
        test_steady_stream(requests_sent + 120);
        test_random_frames(ITEM_TARGET);

        wait_drained();
        repeat (40) @(posedge clk);

        codes_covered = 0;
        foreach (code_seen[i])
            codes_covered += code_seen[i];
        $display("Sent %0d requests and checked %0d class codes, %0d of %0d codes seen.",
                 requests_sent, codes_checked, codes_covered, NUM_CODES);
        $display("Covered empty frames, start transmit, prefixes from the table, near misses,");
        $display("store wrap, a long output hold and a stretch with no idle cycles.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: serial_command_prefix_classifier_top.f
rtl/scp_pkg.sv
rtl/scp_match.sv
rtl/serial_command_prefix_classifier_top.sv
tb/testbench.sv
